### rtl/core/mbbr_pkg.sv
// shared types and constants for the mesh bounding box recenter core
// no dependencies; imported by every module of the core
`default_nettype none

package mbbr_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int COORD_W          = 32;
    localparam int QUEUE_DEPTH      = 2;

    // func codes on the input channel
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_FETCH = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_FETCH,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t    op;
        coord_t x;
        coord_t y;
        coord_t z;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

endpackage

`default_nettype wire

### rtl/core/mbbr_front.sv
// front end: accepts items, decodes func and queues commands for the back end
// depends on mbbr_pkg
`default_nettype none

module mbbr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire logic [1:0]     func,
    input  wire mbbr_pkg::coord_t x_in,
    input  wire mbbr_pkg::coord_t y_in,
    input  wire mbbr_pkg::coord_t z_in,
    output logic                head_valid,
    output mbbr_pkg::cmd_t      head,
    input  wire logic           pop
);
    import mbbr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             known;
    logic             push;
    logic             do_pop;
    cmd_t             cmd;

    assign item_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign accept     = item_valid && item_ready;

    // unused func code is accepted and dropped here
    always_comb
    begin
        cmd.x = x_in;
        cmd.y = y_in;
        cmd.z = z_in;
        known = 1'b1;
        case (func)
            FUNC_LOAD:  cmd.op = OP_LOAD;
            FUNC_FETCH: cmd.op = OP_FETCH;
            FUNC_CLEAR: cmd.op = OP_CLEAR;
            default:
            begin
                cmd.op = OP_CLEAR;
                known  = 1'b0;
            end
        endcase
    end

    assign push       = accept && known;
    assign head_valid = (cnt_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mbbr_back.sv
// back end: vertex store, extent tracking and recentering of fetched vertices
// depends on mbbr_pkg
`default_nettype none

module mbbr_back #(
    parameter int MAX_VERTICES = mbbr_pkg::DEF_MAX_VERTICES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire mbbr_pkg::cmd_t   head,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mbbr_pkg::coord_t      x_out,
    output mbbr_pkg::coord_t      y_out,
    output logic [mbbr_pkg::COORD_W-1:0] z_out,
    output logic                  is_last,
    output logic                  status
);
    import mbbr_pkg::*;

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int W      = COORD_W;

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, rd_ptr_reg;
    coord_t           min_x_reg, max_x_reg, min_y_reg, max_y_reg, min_z_reg, max_z_reg;
    coord_t           mid_x_reg, mid_y_reg;
    logic             last_reg;
    logic [3*W-1:0]   mem [MAX_VERTICES];
    logic [3*W-1:0]   rd_data_reg;

    logic             res_valid_reg;
    coord_t           x_out_reg, y_out_reg;
    logic [W-1:0]     z_out_reg;
    logic             last_out_reg, status_reg;

    logic             out_free, in_range, full;
    logic             do_load, do_clear, issue, emit_end, emit_vtx;
    logic signed [W:0] sum_x, sum_y, dx, dy;
    coord_t           sx, sy, sz, rx, ry;
    logic [W-1:0]     rz;

    assign out_free = !res_valid_reg || result_ready;
    assign in_range = (rd_ptr_reg < count_reg);
    assign full     = (count_reg == CNT_W'(MAX_VERTICES));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (issue)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        do_load  = 1'b0;
        do_clear = 1'b0;
        issue    = 1'b0;
        emit_end = 1'b0;
        emit_vtx = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.op)
                        OP_LOAD:
                        begin
                            pop     = 1'b1;
                            do_load = !full;
                        end
                        OP_FETCH:
                        begin
                            if (in_range)
                            begin
                                pop   = 1'b1;
                                issue = 1'b1;
                            end
                            else if (out_free)
                            begin
                                pop      = 1'b1;
                                emit_end = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            pop      = 1'b1;
                            do_clear = 1'b1;
                        end
                        default: pop = 1'b1;
                    endcase
                end
            end
            BK_READ: emit_vtx = out_free;
            default: ;
        endcase
    end

    // midpoint: 33-bit sum, arithmetic shift right by one
    assign sum_x = {min_x_reg[W-1], min_x_reg} + {max_x_reg[W-1], max_x_reg};
    assign sum_y = {min_y_reg[W-1], min_y_reg} + {max_y_reg[W-1], max_y_reg};

    assign sx = rd_data_reg[3*W-1:2*W];
    assign sy = rd_data_reg[2*W-1:W];
    assign sz = rd_data_reg[W-1:0];
    assign dx = {sx[W-1], sx} - {mid_x_reg[W-1], mid_x_reg};
    assign dy = {sy[W-1], sy} - {mid_y_reg[W-1], mid_y_reg};

    // saturate x and y when the 33-bit difference leaves the 32-bit range; z wraps
    always_comb
    begin
        rx = dx[W-1:0];
        ry = dy[W-1:0];
        if (dx[W] != dx[W-1])
        begin
            rx = dx[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if (dy[W] != dy[W-1])
        begin
            ry = dy[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        rz = sz - min_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            min_z_reg     <= '0;
            max_z_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_clear)
            begin
                count_reg  <= '0;
                rd_ptr_reg <= '0;
                min_x_reg  <= '0;
                max_x_reg  <= '0;
                min_y_reg  <= '0;
                max_y_reg  <= '0;
                min_z_reg  <= '0;
                max_z_reg  <= '0;
            end
            else if (do_load)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    min_x_reg <= head.x;
                    max_x_reg <= head.x;
                    min_y_reg <= head.y;
                    max_y_reg <= head.y;
                    min_z_reg <= head.z;
                    max_z_reg <= head.z;
                end
                else
                begin
                    if (head.x < min_x_reg) min_x_reg <= head.x;
                    if (head.x > max_x_reg) max_x_reg <= head.x;
                    if (head.y < min_y_reg) min_y_reg <= head.y;
                    if (head.y > max_y_reg) max_y_reg <= head.y;
                    if (head.z < min_z_reg) min_z_reg <= head.z;
                    if (head.z > max_z_reg) max_z_reg <= head.z;
                end
            end
            else if (issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (emit_end || emit_vtx)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {head.x, head.y, head.z};
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_ptr_reg[ADDR_W-1:0]];
            mid_x_reg   <= sum_x[W:1];
            mid_y_reg   <= sum_y[W:1];
            last_reg    <= (rd_ptr_reg + 1'b1 == count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_vtx)
        begin
            x_out_reg    <= rx;
            y_out_reg    <= ry;
            z_out_reg    <= rz;
            last_out_reg <= last_reg;
            status_reg   <= 1'b0;
        end
        else if (emit_end)
        begin
            x_out_reg    <= '0;
            y_out_reg    <= '0;
            z_out_reg    <= '0;
            last_out_reg <= 1'b0;
            status_reg   <= 1'b1;
        end
    end

    assign result_valid = res_valid_reg;
    assign x_out        = x_out_reg;
    assign y_out        = y_out_reg;
    assign z_out        = z_out_reg;
    assign is_last      = last_out_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

### rtl/core/mesh_bounding_box_recenter_core.sv
// top level of the mesh bounding box recenter core
// depends on mbbr_pkg, mbbr_front and mbbr_back
//
// usage:
//   input channel (item_valid/item_ready) carries func, x_in, y_in, z_in.
//   func 0 loads a vertex, 1 fetches the next stored vertex recentered on
//   the current bounding box (x, y about the midpoint, z above min z),
//   2 clears the mesh; code 3 is accepted and ignored.
//   only a fetch produces an item on the result channel
//   (result_valid/result_ready); a fetch past the end returns status 1.
//   loads beyond MAX_VERTICES are dropped.
//   the front end queues up to 2 commands, so input keeps flowing while the
//   receiver stalls; once the queue fills, item_ready drops.
//   a load or clear runs once it heads the queue and the back end is idle;
//   a fetch reads the vertex store into a register, then subtracts and
//   saturates into the output registers once the output is free; a fetch
//   past the end waits for a free output, then writes its status item.
//   a pending result stalls a waiting fetch and every command behind it.
//   reset clears the count, read pointer and extents; no clearing pass runs.
`default_nettype none

module mesh_bounding_box_recenter_core #(
    parameter int MAX_VERTICES = mbbr_pkg::DEF_MAX_VERTICES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire logic [1:0]       func,
    input  wire mbbr_pkg::coord_t x_in,
    input  wire mbbr_pkg::coord_t y_in,
    input  wire mbbr_pkg::coord_t z_in,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mbbr_pkg::coord_t      x_out,
    output mbbr_pkg::coord_t      y_out,
    output logic [mbbr_pkg::COORD_W-1:0] z_out,
    output logic                  is_last,
    output logic                  status
);
    import mbbr_pkg::*;

    logic head_valid;
    cmd_t head;
    logic pop;

    mbbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .func       (func),
        .x_in       (x_in),
        .y_in       (y_in),
        .z_in       (z_in),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    mbbr_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .x_out        (x_out),
        .y_out        (y_out),
        .z_out        (z_out),
        .is_last      (is_last),
        .status       (status)
    );

endmodule

`default_nettype wire

### rtl/core/mbbr_checker.sv
// port-level checks for the mesh bounding box recenter core, with its bind
// depends on mbbr_pkg and mesh_bounding_box_recenter_core
`default_nettype none

module mbbr_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire mbbr_pkg::coord_t     x_out,
    input wire mbbr_pkg::coord_t     y_out,
    input wire logic [mbbr_pkg::COORD_W-1:0] z_out,
    input wire logic                 is_last,
    input wire logic                 status
);
    import mbbr_pkg::*;

    // result item holds while stalled
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result_valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(x_out) && $stable(y_out) && $stable(z_out)
            && $stable(is_last) && $stable(status))
        else $error("result payload changed while stalled");

    // end-of-mesh item carries zero fields and no last mark
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |->
            x_out == '0 && y_out == '0 && z_out == '0 && !is_last)
        else $error("status item with nonzero fields");

    // nothing offered while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result_valid during reset");

endmodule

bind mesh_bounding_box_recenter_core mbbr_checker u_mbbr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .x_out        (x_out),
    .y_out        (y_out),
    .z_out        (z_out),
    .is_last      (is_last),
    .status       (status)
);

`default_nettype wire
